[src/console_line_discipline_core_macros.svh]
// assertion macros shared by the console line discipline modules
// each expects clk and arst_n in scope
`ifndef CONSOLE_LINE_DISCIPLINE_CORE_MACROS_SVH
`define CONSOLE_LINE_DISCIPLINE_CORE_MACROS_SVH

// condition must never hold outside reset
`define CLD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CLD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/cld_pkg.sv]
`default_nettype none

package cld_pkg;

	// line length cap and derived limit clamp
	localparam int MAX_LINE = 128;
	localparam logic [7:0] LIMIT_CAP = 8'((MAX_LINE < 255) ? MAX_LINE : 255);

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// most results that one item can cause
	localparam int MAX_RES = 3;

	// character codes
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_CHAR  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TX    = 2'd0,
		KIND_STORE = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_WRITE_MODE  = 3'd0,
		CFG_CRLF_ON     = 3'd1,
		CFG_LINE_MODE   = 3'd2,
		CFG_ECHO_ON     = 3'd3,
		CFG_READLINE_ON = 3'd4,
		CFG_MAX_LENGTH  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] char_in;
	} src_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic [7:0] position;
		logic       last;
	} res_item_t;

	// one queue entry: the results of one input item
	typedef struct packed {
		logic [1:0]                num;
		res_item_t [MAX_RES-1:0]   res;
	} cld_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic res_item_t mk_res(kind_t kind, logic [7:0] b, logic [7:0] pos);
		res_item_t r;
		r.kind     = kind;
		r.out_byte = b;
		r.position = pos;
		r.last     = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

[src/cld_front.sv]
`default_nettype none

module cld_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire cld_pkg::src_item_t   src_item,
	input  wire cld_pkg::q_status_t   q_status,
	output logic                      push,
	output cld_pkg::cld_entry_t       push_entry
);
	import cld_pkg::*;

	logic       write_mode_q, crlf_on_q, line_mode_q, echo_on_q, readline_on_q;
	logic [7:0] max_length_q;
	logic [7:0] count_q, cnt_d;
	logic       active_q, act_d;
	logic [7:0] lim, cnt_inc, ch;
	logic [1:0] n;
	res_item_t [MAX_RES-1:0] res;
	logic       accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_mode_q  <= 1'b0;
			crlf_on_q     <= 1'b1;
			line_mode_q   <= 1'b1;
			echo_on_q     <= 1'b0;
			readline_on_q <= 1'b0;
			max_length_q  <= 8'd80;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WRITE_MODE:  write_mode_q  <= cfg_data[0];
				CFG_CRLF_ON:     crlf_on_q     <= cfg_data[0];
				CFG_LINE_MODE:   line_mode_q   <= cfg_data[0];
				CFG_ECHO_ON:     echo_on_q     <= cfg_data[0];
				CFG_READLINE_ON: readline_on_q <= cfg_data[0];
				CFG_MAX_LENGTH:  max_length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective limit
	assign lim = (max_length_q > LIMIT_CAP) ? LIMIT_CAP : max_length_q;

	assign src_stall = q_status.full;
	assign accept    = src_valid && !src_stall;
	assign ch        = src_item.char_in;
	assign cnt_inc   = count_q + 8'd1;

	// classify the item and build its result list
	always_comb begin
		cnt_d = count_q;
		act_d = active_q;
		n     = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = mk_res(KIND_TX, CH_NUL, 8'h00);
		end
		if (src_item.mode == MODE_START) begin
			cnt_d = 8'h00;
			act_d = 1'b1;
			if (lim == 8'h00 && (write_mode_q || !readline_on_q)) begin
				res[n] = mk_res(KIND_DONE, CH_NUL, 8'h00);
				n = n + 2'd1;
				act_d = 1'b0;
			end
		end else if (active_q) begin
			if (write_mode_q) begin
				if (line_mode_q && ch == CH_NUL) begin
					res[n] = mk_res(KIND_DONE, CH_NUL, count_q);
					n = n + 2'd1;
					act_d = 1'b0;
				end else begin
					cnt_d = cnt_inc;
					if (crlf_on_q && ch == CH_LF) begin
						res[n] = mk_res(KIND_TX, CH_CR, 8'h00);
						n = n + 2'd1;
					end
					res[n] = mk_res(KIND_TX, ch, 8'h00);
					n = n + 2'd1;
					if (cnt_inc >= lim) begin
						res[n] = mk_res(KIND_DONE, CH_NUL, cnt_inc);
						n = n + 2'd1;
						act_d = 1'b0;
					end
				end
			end else if (readline_on_q && (ch == CH_BS || ch == CH_DEL)) begin
				// erase sequence
				if (count_q != 8'h00) begin
					cnt_d  = count_q - 8'd1;
					res[0] = mk_res(KIND_TX, CH_BS, 8'h00);
					res[1] = mk_res(KIND_TX, CH_SP, 8'h00);
					res[2] = mk_res(KIND_TX, CH_BS, 8'h00);
					n = 2'd3;
				end
			end else if (line_mode_q && (ch == CH_CR || ch == CH_LF)) begin
				if (count_q < lim) begin
					res[n] = mk_res(KIND_STORE, CH_NUL, count_q);
					n = n + 2'd1;
				end
				res[n] = mk_res(KIND_DONE, CH_NUL, count_q);
				n = n + 2'd1;
				act_d = 1'b0;
			end else begin
				if (echo_on_q) begin
					res[n] = mk_res(KIND_TX, ch, 8'h00);
					n = n + 2'd1;
				end
				if (!(readline_on_q && count_q >= lim)) begin
					res[n] = mk_res(KIND_STORE, ch, count_q);
					n = n + 2'd1;
					cnt_d = cnt_inc;
				end
				if (!readline_on_q && cnt_d >= lim) begin
					res[n] = mk_res(KIND_DONE, CH_NUL, cnt_d);
					n = n + 2'd1;
					act_d = 1'b0;
				end
			end
		end
		// mark the final result of this item
		if (n != 2'd0) begin
			res[n - 2'd1].last = 1'b1;
		end
	end

	// session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 8'h00;
			active_q <= 1'b0;
		end else if (accept) begin
			count_q  <= cnt_d;
			active_q <= act_d;
		end
	end

	assign push           = accept && (n != 2'd0);
	assign push_entry.num = n;
	assign push_entry.res = res;

endmodule

`default_nettype wire

[src/cld_queue.sv]
`default_nettype none

module cld_queue #(
	parameter int DEPTH = cld_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire cld_pkg::cld_entry_t  push_entry,
	input  wire logic                 pop,
	output cld_pkg::cld_entry_t       head,
	output cld_pkg::q_status_t        q_status
);
	import cld_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

	cld_entry_t        mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [OW-1:0]     occ_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				occ_q <= occ_q + OW'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - OW'(1);
			end
		end
	end

	assign head           = mem_q[rd_ptr_q];
	assign q_status.empty = (occ_q == '0);
	assign q_status.full  = (occ_q == FULL_OCC);

`include "console_line_discipline_core_macros.svh"

	`CLD_ASSERT_NEVER(a_no_push_full, push && q_status.full, "push into full queue")
	`CLD_ASSERT_IMPL(a_pop_nonempty, pop, !q_status.empty, "pop from empty queue")
	`CLD_ASSERT_IMPL(a_push_has_res, push, push_entry.num != 2'd0, "empty entry pushed")

endmodule

`default_nettype wire

[src/cld_back.sv]
`default_nettype none

module cld_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cld_pkg::cld_entry_t  head,
	input  wire cld_pkg::q_status_t   q_status,
	output logic                      pop,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output cld_pkg::res_item_t        res_item
);
	import cld_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	res_item_t  item_q;
	logic       load;
	logic       at_end;
	res_item_t  cur;

	assign cur    = head.res[idx_q];
	assign load   = !q_status.empty && (!valid_q || !res_stall);
	assign at_end = (idx_q == head.num - 2'd1);
	assign pop    = load && at_end;

	// result index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= cur;
		end
	end

	assign res_valid = valid_q;
	assign res_item  = item_q;

`include "console_line_discipline_core_macros.svh"

	`CLD_ASSERT_IMPL(a_idx_in_entry, !q_status.empty, idx_q < head.num, "index past entry")
	`CLD_ASSERT_IMPL(a_pop_on_last, pop, cur.last, "entry retired before its last beat")
	`CLD_ASSERT_IMPL(a_last_ends_entry, load && cur.last, at_end, "last beat inside entry")

endmodule

`default_nettype wire

[src/console_line_discipline_core.sv]
`default_nettype none

// Console character engine. A start beat (mode 0) clears the count and arms a
// session; character beats then either go to transmit (write mode, with CR before
// LF when enabled) or are stored and optionally echoed (read mode, with BS/DEL
// editing in readline mode), and a finished result carries the final count. The
// front classifies one input beat per cycle and writes its one to three results
// as one entry into a small queue; the back has a single result port and hands
// out one result per cycle, while the receiver does not stall, from an output
// register. Items that cause no result put no entry into the queue, and the front
// takes new beats while the back still hands out earlier results. The front stalls only when the queue is full.
module console_line_discipline_core #(
	parameter int Q_DEPTH = cld_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire cld_pkg::src_item_t  src_item,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output cld_pkg::res_item_t       res_item
);
	import cld_pkg::*;

	logic       push, pop;
	cld_entry_t push_entry, head;
	q_status_t  q_status;

	cld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_item   (src_item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	cld_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	cld_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

[tb/cld_line_checker.sv]
module cld_line_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                src_valid,
	input  wire logic                src_stall,
	input  wire cld_pkg::src_item_t  src_item,
	input  wire logic                res_valid,
	input  wire logic                res_stall,
	input  wire cld_pkg::res_item_t  res_item,
	output int                       errors,
	output int                       pending,
	output int                       checked
);
	import cld_pkg::*;

	// shadow of the register file
	logic       wr_mode;
	logic       crlf_en;
	logic       line_en;
	logic       echo_en;
	logic       edit_en;
	logic [7:0] max_len;

	// session state
	logic [7:0] line_count;
	logic       session_on;

	// results of the beat being predicted, then all results still awaited
	res_item_t  beat_out[$];
	res_item_t  awaited_out[$];
	res_item_t  want;
	int         err_n;
	int         seen_n;

	task automatic add_result(input kind_t k, input logic [7:0] b, input logic [7:0] pos);
		res_item_t r;
		r.kind     = k;
		r.out_byte = b;
		r.position = pos;
		r.last     = 1'b0;
		beat_out.push_back(r);
	endtask

	task automatic end_session();
		add_result(KIND_DONE, CH_NUL, line_count);
		session_on = 1'b0;
	endtask

	// one source beat through the line discipline
	task automatic step_line_discipline(input src_item_t it);
		logic [7:0] lim;
		logic [7:0] ch;
		res_item_t  r;
		lim = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
		ch  = it.char_in;
		beat_out.delete();
		if (it.mode == MODE_START) begin
			line_count = '0;
			session_on = 1'b1;
			if (line_count >= lim && (wr_mode || !edit_en))
				end_session();
		end else if (session_on) begin
			if (wr_mode) begin
				// write mode: send bytes, NUL ends the line in line mode
				if (line_en && ch == CH_NUL) begin
					end_session();
				end else begin
					line_count++;
					if (crlf_en && ch == CH_LF)
						add_result(KIND_TX, CH_CR, 8'd0);
					add_result(KIND_TX, ch, 8'd0);
					if (line_count >= lim)
						end_session();
				end
			end else if (edit_en && (ch == CH_BS || ch == CH_DEL)) begin
				// erase one byte on the console, nothing to erase at the line start
				if (line_count != 8'd0) begin
					line_count--;
					add_result(KIND_TX, CH_BS, 8'd0);
					add_result(KIND_TX, CH_SP, 8'd0);
					add_result(KIND_TX, CH_BS, 8'd0);
				end
			end else if (line_en && (ch == CH_CR || ch == CH_LF)) begin
				// line end: terminate the string if it fits
				if (line_count < lim)
					add_result(KIND_STORE, CH_NUL, line_count);
				end_session();
			end else begin
				if (echo_en)
					add_result(KIND_TX, ch, 8'd0);
				if (!(edit_en && line_count >= lim)) begin
					add_result(KIND_STORE, ch, line_count);
					line_count++;
				end
				if (!edit_en && line_count >= lim)
					end_session();
			end
		end
		// flag the final result of this beat and queue them all
		if (beat_out.size() != 0) begin
			r = beat_out[beat_out.size() - 1];
			r.last = 1'b1;
			beat_out[beat_out.size() - 1] = r;
		end
		foreach (beat_out[i])
			awaited_out.push_back(beat_out[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_mode    = 1'b0;
			crlf_en    = 1'b1;
			line_en    = 1'b1;
			echo_en    = 1'b0;
			edit_en    = 1'b0;
			max_len    = 8'd80;
			line_count = '0;
			session_on = 1'b0;
			awaited_out.delete();
			err_n      = 0;
			seen_n     = 0;
		end else begin
			// a beat on the same edge still sees the old registers
			if (src_valid && !src_stall)
				step_line_discipline(src_item);

			// register writes take effect for the next beat
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WRITE_MODE:  wr_mode = cfg_data[0];
					CFG_CRLF_ON:     crlf_en = cfg_data[0];
					CFG_LINE_MODE:   line_en = cfg_data[0];
					CFG_ECHO_ON:     echo_en = cfg_data[0];
					CFG_READLINE_ON: edit_en = cfg_data[0];
					CFG_MAX_LENGTH:  max_len = cfg_data;
					default: ;
				endcase
			end

			// compare each result beat with the oldest prediction
			if (res_valid && !res_stall) begin
				seen_n++;
				if (awaited_out.size() == 0) begin
					$error("unexpected result beat: kind %0d byte %02h position %0d last %0b",
						res_item.kind, res_item.out_byte, res_item.position, res_item.last);
					err_n++;
				end else begin
					want = awaited_out.pop_front();
					if (res_item.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, res_item.kind);
						err_n++;
					end
					if (res_item.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte,
							res_item.out_byte);
						err_n++;
					end
					if (res_item.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position,
							res_item.position);
						err_n++;
					end
					if (res_item.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, res_item.last);
						err_n++;
					end
				end
			end
		end
		errors  <= err_n;
		checked <= seen_n;
		pending <= awaited_out.size();
	end

endmodule

[tb/tb_console_line_discipline_core.sv]
module tb_console_line_discipline_core;
	import cld_pkg::*;

	localparam int WATCHDOG_CYCLES = 400000;
	localparam int DRAIN_BOUND     = 20000;
	localparam int SETTLE_CYCLES   = 16;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	src_item_t  src_item  = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_item_t  res_item;

	int errors;
	int pending;
	int checked;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int beats_sent  = 0;
	int loads_done  = 0;
	int cycle_count = 0;
	bit stuck       = 1'b0;

	console_line_discipline_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	cld_line_checker line_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// one source beat, then at times a random idle gap
	task automatic send_beat(input mode_t m, input logic [7:0] c);
		src_item_t it;
		it.mode    = m;
		it.char_in = c;
		src_valid <= 1'b1;
		src_item  <= it;
		do @(posedge clk); while (src_stall);
		beats_sent++;
		if ($urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			src_item  <= src_item_t'(9'($urandom_range(511)));
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// hold off until every predicted result has come out, then let the front settle
	task automatic wait_drained();
		int waited;
		waited = 0;
		src_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < DRAIN_BOUND);
		if (pending != 0) begin
			$error("%0d result beats never arrived", pending);
			stuck = 1'b1;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic wm, input logic crlf, input logic line,
		input logic echo, input logic edit, input logic [7:0] max_len);
		wait_drained();
		put_reg(CFG_WRITE_MODE, {7'd0, wm});
		put_reg(CFG_CRLF_ON, {7'd0, crlf});
		put_reg(CFG_LINE_MODE, {7'd0, line});
		put_reg(CFG_ECHO_ON, {7'd0, echo});
		put_reg(CFG_READLINE_ON, {7'd0, edit});
		put_reg(CFG_MAX_LENGTH, max_len);
		cfg_we <= 1'b0;
		loads_done++;
	endtask

	// mostly short lines so sessions end often, with the extremes now and then
	task automatic load_random_settings();
		logic [7:0] max_len;
		case ($urandom_range(9))
			0:       max_len = 8'd0;
			1:       max_len = 8'd128;
			2:       max_len = 8'd80;
			default: max_len = 8'($urandom_range(8, 1));
		endcase
		load_settings(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), max_len);
	endtask

	// console bytes weighted toward control characters
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return CH_CR;
		else if (r < 12)
			return CH_LF;
		else if (r < 17)
			return CH_BS;
		else if (r < 22)
			return CH_DEL;
		else if (r < 27)
			return CH_NUL;
		else if (r < 65)
			return 8'($urandom_range(8'h7E, 8'h21));
		return 8'($urandom_range(255));
	endfunction

	initial begin
		int stop_at;

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: character while no session is open
		send_beat(MODE_CHAR, 8'h41);

		// write mode with CR before LF, NUL ends the line
		load_settings(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd80);
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_CHAR, 8'h68);
		send_beat(MODE_CHAR, CH_LF);
		send_beat(MODE_CHAR, 8'hFF);
		send_beat(MODE_CHAR, CH_NUL);

		// write mode without line end, session ends on the limit
		load_settings(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd2);
		send_beat(MODE_START, 8'hFF);
		send_beat(MODE_CHAR, CH_LF);
		send_beat(MODE_CHAR, CH_NUL);

		// zero limit finishes on the start beat
		load_settings(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0);
		send_beat(MODE_START, 8'h00);

		// readline with echo: erase, erase at line start, overflow, line end at limit
		load_settings(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'd3);
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_CHAR, 8'h61);
		send_beat(MODE_CHAR, CH_BS);
		send_beat(MODE_CHAR, CH_DEL);
		send_beat(MODE_CHAR, 8'h62);
		send_beat(MODE_CHAR, 8'h63);
		send_beat(MODE_CHAR, 8'h64);
		send_beat(MODE_CHAR, 8'h65);
		send_beat(MODE_CHAR, CH_CR);

		// read mode, zero limit, then a character after the session closed
		load_settings(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0);
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_CHAR, 8'h7A);

		// plain read at the largest limit: backspace stored, restart, line end with room
		load_settings(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd128);
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_CHAR, CH_BS);
		send_beat(MODE_START, 8'h00);
		send_beat(MODE_CHAR, 8'h79);
		send_beat(MODE_CHAR, CH_LF);

		// random sessions under four idling patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 45; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 45; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			repeat (2) begin
				load_random_settings();
				stop_at = beats_sent + 8;
				while (beats_sent < stop_at) begin
					// occasional stray characters ahead of the start
					if ($urandom_range(99) < 15)
						repeat ($urandom_range(2, 1)) send_beat(MODE_CHAR, pick_char());
					send_beat(MODE_START, 8'($urandom_range(255)));
					repeat ($urandom_range(10, 1)) begin
						if ($urandom_range(99) < 5)
							send_beat(MODE_START, 8'($urandom_range(255)));
						else
							send_beat(MODE_CHAR, pick_char());
					end
				end
			end
		end

		wait_drained();
		$display("sent %0d source beats across %0d register settings, compared %0d results",
			beats_sent, loads_done, checked);
		$display("idling: none, sender only, receiver only, and both sides");
		if (errors == 0 && !stuck)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
